>>> hdl/fractional_id_allocator_core_assert.svh
// Assertion macros used by the allocator datapath.
`ifndef FRACTIONAL_ID_ALLOCATOR_CORE_ASSERT_SVH
`define FRACTIONAL_ID_ALLOCATOR_CORE_ASSERT_SVH

// Same-cycle implication, disabled during reset
`define FIA_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("fia: assertion failed");

// Next-cycle implication, disabled during reset
`define FIA_ASSERT_NXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("fia: assertion failed");

`endif

>>> hdl/fia_pkg.sv
// Shared constants, codes and controller/datapath interface types.
package fia_pkg;

  // Sizing
  localparam int MAX_IDS   = 16;
  localparam int FRAC_BITS = 16;
  localparam int ID_W      = $clog2(MAX_IDS);
  localparam int CNT_W     = $clog2(MAX_IDS + 1);
  localparam int AMT_W     = FRAC_BITS + 1;
  localparam int Q_W       = 21;
  localparam int K_W       = Q_W - FRAC_BITS;
  localparam int CMD_W     = 2;
  localparam int ST_W      = 3;

  localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_IDS);
  localparam logic [AMT_W-1:0] ONE_AMT = {1'b1, {FRAC_BITS{1'b0}}};
  localparam logic [Q_W-1:0]   ONE_Q   = Q_W'(ONE_AMT);

  // Command codes
  localparam logic [CMD_W-1:0] CMD_ACQ  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_REL  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_INIT = 2'd2;

  // Result status codes
  localparam logic [ST_W-1:0] ST_OK     = 3'd0;
  localparam logic [ST_W-1:0] ST_INSUFF = 3'd1;
  localparam logic [ST_W-1:0] ST_BADQ   = 3'd2;
  localparam logic [ST_W-1:0] ST_OVER   = 3'd3;
  localparam logic [ST_W-1:0] ST_FULL   = 3'd4;

  // Datapath micro-operations
  localparam int OP_W = 5;
  typedef logic [OP_W-1:0] op_t;
  localparam op_t OP_NONE      = 5'd0;
  localparam op_t OP_LOAD      = 5'd1;
  localparam op_t OP_FILL      = 5'd2;
  localparam op_t OP_INIT_END  = 5'd3;
  localparam op_t OP_POP       = 5'd4;
  localparam op_t OP_PUSH      = 5'd5;
  localparam op_t OP_PRD       = 5'd6;
  localparam op_t OP_NEXT      = 5'd7;
  localparam op_t OP_TAKE      = 5'd8;
  localparam op_t OP_PRD_LAST  = 5'd9;
  localparam op_t OP_MOVE_LAST = 5'd10;
  localparam op_t OP_SPLIT     = 5'd11;
  localparam op_t OP_MERGE     = 5'd12;
  localparam op_t OP_APPEND    = 5'd13;
  localparam op_t OP_SHRD      = 5'd14;
  localparam op_t OP_SHWR      = 5'd15;
  localparam op_t OP_PC_DEC    = 5'd16;

  // Result source select
  typedef logic [1:0] res_sel_t;
  localparam res_sel_t RES_NONE = 2'd0;
  localparam res_sel_t RES_ZERO = 2'd1;
  localparam res_sel_t RES_POP  = 2'd2;
  localparam res_sel_t RES_FRAC = 2'd3;

  // Controller to datapath
  typedef struct packed {
    op_t             op;
    res_sel_t        res_sel;
    logic [ST_W-1:0] status;
    logic            last;
  } dp_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic [CMD_W-1:0] cmd;
    logic q_zero;
    logic q_whole;
    logic q_aligned;
    logic q_one;
    logic q_over_one;
    logic k_over;
    logic fill_done;
    logic pop_done;
    logic ws_empty;
    logic ws_full;
    logic pl_full;
    logic scan_end;
    logic last_entry;
    logic fit;
    logic take_zero;
    logic match;
    logic sum_over;
    logic sum_one;
  } dp_stat_t;

endpackage

>>> hdl/fractional_id_allocator_core.sv
// Fractional ID allocator top level: controller plus datapath.
//
// A command is taken when start is high and busy is low. Each result is
// shown on the result ports for exactly one cycle with result_valid high;
// the receiver cannot stall, so it must take every beat as it comes. Whole
// and partial IDs live in small single-port-read memories, and the
// sequencer touches one entry per step, so timing is data dependent. Init
// writes IDs 0..n-1 (n = the cfg_data value, capped at 16); a whole
// acquire of k IDs pops and emits one result beat per ID; a fractional
// acquire or a release scans the partial list one entry at a time, and a
// release that promotes an ID to whole shifts every entry behind it down
// to close the gap. The last result beat of a command lands in the cycle
// busy drops.
// Configuration is written through cfg_we/cfg_data.
module fractional_id_allocator_core (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  output logic                        busy,
  input  logic [fia_pkg::CMD_W-1:0]   cmd,
  input  logic [fia_pkg::Q_W-1:0]     quantity,
  input  logic [fia_pkg::ID_W-1:0]    id,
  input  logic                        cfg_we,
  input  logic [fia_pkg::CNT_W-1:0]   cfg_data,
  output logic                        result_valid,
  output logic [fia_pkg::ID_W-1:0]    granted_id,
  output logic [fia_pkg::AMT_W-1:0]   amount,
  output logic [fia_pkg::ST_W-1:0]    status,
  output logic                        last
);

  fia_pkg::dp_cmd_t  ctl;
  fia_pkg::dp_stat_t stat;

  // Sequencer
  fia_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .stat  (stat),
    .ctl   (ctl)
  );

  // Storage and arithmetic
  fia_dpath u_dpath (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_data     (cfg_data),
    .cmd          (cmd),
    .quantity     (quantity),
    .id           (id),
    .ctl          (ctl),
    .stat         (stat),
    .result_valid (result_valid),
    .granted_id   (granted_id),
    .amount       (amount),
    .status       (status),
    .last         (last)
  );

endmodule

>>> hdl/fia_dpath.sv
// Allocator datapath: ID stack, partial list, counters and result register.
`include "fractional_id_allocator_core_assert.svh"

module fia_dpath (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_we,
  input  logic [fia_pkg::CNT_W-1:0]   cfg_data,
  input  logic [fia_pkg::CMD_W-1:0]   cmd,
  input  logic [fia_pkg::Q_W-1:0]     quantity,
  input  logic [fia_pkg::ID_W-1:0]    id,
  input  fia_pkg::dp_cmd_t            ctl,
  output fia_pkg::dp_stat_t           stat,
  output logic                        result_valid,
  output logic [fia_pkg::ID_W-1:0]    granted_id,
  output logic [fia_pkg::AMT_W-1:0]   amount,
  output logic [fia_pkg::ST_W-1:0]    status,
  output logic                        last
);

  // Storage
  logic [fia_pkg::ID_W-1:0]  whole_mem [fia_pkg::MAX_IDS];
  logic [fia_pkg::ID_W-1:0]  pid_mem   [fia_pkg::MAX_IDS];
  logic [fia_pkg::AMT_W-1:0] pleft_mem [fia_pkg::MAX_IDS];

  // Control registers
  logic [fia_pkg::CNT_W-1:0] init_cnt;
  logic [fia_pkg::CNT_W-1:0] wc;
  logic [fia_pkg::CNT_W-1:0] pc;

  // Working registers
  logic [fia_pkg::CMD_W-1:0] cmd_r;
  logic [fia_pkg::Q_W-1:0]   q_r;
  logic [fia_pkg::ID_W-1:0]  id_r;
  logic [fia_pkg::CNT_W-1:0] idx;
  logic [fia_pkg::CNT_W-1:0] fill_n;
  logic [fia_pkg::K_W-1:0]   kleft;
  logic [fia_pkg::ID_W-1:0]  gid_r;
  logic [fia_pkg::ID_W-1:0]  stack_rd;
  logic [fia_pkg::ID_W-1:0]  prd_id;
  logic [fia_pkg::AMT_W-1:0] prd_left;

  // Memory port controls
  logic                      ws_we;
  logic [fia_pkg::ID_W-1:0]  ws_waddr;
  logic [fia_pkg::ID_W-1:0]  ws_wdata;
  logic                      ws_re;
  logic [fia_pkg::ID_W-1:0]  ws_raddr;
  logic                      pl_we;
  logic [fia_pkg::ID_W-1:0]  pl_waddr;
  logic [fia_pkg::ID_W-1:0]  pl_wid;
  logic [fia_pkg::AMT_W-1:0] pl_wleft;
  logic                      pl_re;
  logic [fia_pkg::ID_W-1:0]  pl_raddr;

  logic [fia_pkg::AMT_W-1:0] q_frac;
  logic [fia_pkg::AMT_W:0]   sum;
  logic [fia_pkg::CNT_W-1:0] idx_inc;
  logic [fia_pkg::CNT_W-1:0] wc_dec;
  logic [fia_pkg::CNT_W-1:0] pc_dec;

  assign q_frac  = q_r[fia_pkg::AMT_W-1:0];
  assign sum     = {1'b0, prd_left} + {1'b0, q_frac};
  assign idx_inc = idx + fia_pkg::CNT_W'(1);
  assign wc_dec  = wc - fia_pkg::CNT_W'(1);
  assign pc_dec  = pc - fia_pkg::CNT_W'(1);

  // Status flags to the controller
  always_comb begin
    stat.cmd        = cmd_r;
    stat.q_zero     = (q_r == '0);
    stat.q_whole    = (q_r >= fia_pkg::ONE_Q);
    stat.q_aligned  = (q_r[fia_pkg::FRAC_BITS-1:0] == '0);
    stat.q_one      = (q_r == fia_pkg::ONE_Q);
    stat.q_over_one = (q_r > fia_pkg::ONE_Q);
    stat.k_over     = (fia_pkg::CNT_W'(q_r[fia_pkg::Q_W-1:fia_pkg::FRAC_BITS]) > wc);
    stat.fill_done  = (idx == fill_n);
    stat.pop_done   = (kleft == '0);
    stat.ws_empty   = (wc == '0);
    stat.ws_full    = (wc == fia_pkg::MAX_CNT);
    stat.pl_full    = (pc == fia_pkg::MAX_CNT);
    stat.scan_end   = (idx == pc);
    stat.last_entry = (idx_inc == pc);
    stat.fit        = ({{(fia_pkg::Q_W-fia_pkg::AMT_W){1'b0}}, prd_left} >= q_r);
    stat.take_zero  = (prd_left == q_frac);
    stat.match      = (prd_id == id_r);
    stat.sum_over   = (sum > {1'b0, fia_pkg::ONE_AMT});
    stat.sum_one    = (sum == {1'b0, fia_pkg::ONE_AMT});
  end

  // Memory port decode
  always_comb begin
    ws_we    = 1'b0;
    ws_waddr = wc[fia_pkg::ID_W-1:0];
    ws_wdata = id_r;
    ws_re    = 1'b0;
    ws_raddr = wc_dec[fia_pkg::ID_W-1:0];
    pl_we    = 1'b0;
    pl_waddr = idx[fia_pkg::ID_W-1:0];
    pl_wid   = prd_id;
    pl_wleft = prd_left;
    pl_re    = 1'b0;
    pl_raddr = idx[fia_pkg::ID_W-1:0];
    unique case (ctl.op)
      fia_pkg::OP_FILL: begin
        ws_we    = 1'b1;
        ws_waddr = idx[fia_pkg::ID_W-1:0];
        ws_wdata = idx[fia_pkg::ID_W-1:0];
      end
      fia_pkg::OP_POP:  ws_re = 1'b1;
      fia_pkg::OP_PUSH: ws_we = 1'b1;
      fia_pkg::OP_PRD:  pl_re = 1'b1;
      fia_pkg::OP_TAKE: begin
        pl_we    = 1'b1;
        pl_wleft = prd_left - q_frac;
      end
      fia_pkg::OP_PRD_LAST: begin
        pl_re    = 1'b1;
        pl_raddr = pc_dec[fia_pkg::ID_W-1:0];
      end
      fia_pkg::OP_MOVE_LAST: pl_we = 1'b1;
      fia_pkg::OP_SPLIT: begin
        pl_we    = 1'b1;
        pl_waddr = pc[fia_pkg::ID_W-1:0];
        pl_wid   = stack_rd;
        pl_wleft = fia_pkg::ONE_AMT - q_frac;
      end
      fia_pkg::OP_MERGE: begin
        pl_we    = 1'b1;
        pl_wleft = sum[fia_pkg::AMT_W-1:0];
      end
      fia_pkg::OP_APPEND: begin
        pl_we    = 1'b1;
        pl_waddr = pc[fia_pkg::ID_W-1:0];
        pl_wid   = id_r;
        pl_wleft = q_frac;
      end
      fia_pkg::OP_SHRD: begin
        pl_re    = 1'b1;
        pl_raddr = idx_inc[fia_pkg::ID_W-1:0];
      end
      fia_pkg::OP_SHWR: pl_we = 1'b1;
      default: ;
    endcase
  end

  // Whole-ID stack
  always_ff @(posedge clk) begin
    if (ws_we) whole_mem[ws_waddr] <= ws_wdata;
    if (ws_re) stack_rd <= whole_mem[ws_raddr];
  end

  // Partial list
  always_ff @(posedge clk) begin
    if (pl_we) begin
      pid_mem[pl_waddr]   <= pl_wid;
      pleft_mem[pl_waddr] <= pl_wleft;
    end
    if (pl_re) begin
      prd_id   <= pid_mem[pl_raddr];
      prd_left <= pleft_mem[pl_raddr];
    end
  end

  // Counters and config register
  always_ff @(posedge clk) begin
    if (rst) begin
      init_cnt     <= '0;
      wc           <= '0;
      pc           <= '0;
      result_valid <= 1'b0;
    end else begin
      if (cfg_we) init_cnt <= cfg_data;
      result_valid <= (ctl.res_sel != fia_pkg::RES_NONE);
      unique case (ctl.op)
        fia_pkg::OP_INIT_END: begin
          wc <= fill_n;
          pc <= '0;
        end
        fia_pkg::OP_POP:       wc <= wc_dec;
        fia_pkg::OP_PUSH:      wc <= wc + fia_pkg::CNT_W'(1);
        fia_pkg::OP_SPLIT,
        fia_pkg::OP_APPEND:    pc <= pc + fia_pkg::CNT_W'(1);
        fia_pkg::OP_MOVE_LAST,
        fia_pkg::OP_PC_DEC:    pc <= pc_dec;
        default: ;
      endcase
    end
  end

  // Working registers
  always_ff @(posedge clk) begin
    unique case (ctl.op)
      fia_pkg::OP_LOAD: begin
        cmd_r  <= cmd;
        q_r    <= quantity;
        id_r   <= id;
        idx    <= '0;
        kleft  <= quantity[fia_pkg::Q_W-1:fia_pkg::FRAC_BITS];
        fill_n <= (init_cnt > fia_pkg::MAX_CNT) ? fia_pkg::MAX_CNT : init_cnt;
      end
      fia_pkg::OP_FILL,
      fia_pkg::OP_NEXT,
      fia_pkg::OP_SHWR:  idx <= idx_inc;
      fia_pkg::OP_POP:   kleft <= kleft - fia_pkg::K_W'(1);
      fia_pkg::OP_TAKE:  gid_r <= prd_id;
      fia_pkg::OP_SPLIT: gid_r <= stack_rd;
      default: ;
    endcase
  end

  // Result register
  always_ff @(posedge clk) begin
    status <= ctl.status;
    last   <= ctl.last;
    unique case (ctl.res_sel)
      fia_pkg::RES_POP: begin
        granted_id <= stack_rd;
        amount     <= fia_pkg::ONE_AMT;
      end
      fia_pkg::RES_FRAC: begin
        granted_id <= gid_r;
        amount     <= q_frac;
      end
      default: begin
        granted_id <= '0;
        amount     <= '0;
      end
    endcase
  end

  // Checks
  `FIA_ASSERT_IMP(a_pop_nonempty, clk, rst, ctl.op == fia_pkg::OP_POP, wc != '0)
  `FIA_ASSERT_IMP(a_push_room, clk, rst, ctl.op == fia_pkg::OP_PUSH, wc < fia_pkg::MAX_CNT)
  `FIA_ASSERT_IMP(a_add_room, clk, rst,
                  ctl.op == fia_pkg::OP_SPLIT || ctl.op == fia_pkg::OP_APPEND,
                  pc < fia_pkg::MAX_CNT)
  `FIA_ASSERT_NXT(a_load_quiet, clk, rst, ctl.op == fia_pkg::OP_LOAD, !result_valid)

endmodule

>>> hdl/fia_ctrl.sv
// Allocator controller: sequences datapath operations for each command.
module fia_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  fia_pkg::dp_stat_t stat,
  output fia_pkg::dp_cmd_t  ctl
);

  localparam int S_W = 4;
  localparam logic [S_W-1:0] S_IDLE     = 4'd0;
  localparam logic [S_W-1:0] S_DECODE   = 4'd1;
  localparam logic [S_W-1:0] S_FILL     = 4'd2;
  localparam logic [S_W-1:0] S_POP_RD   = 4'd3;
  localparam logic [S_W-1:0] S_POP_OUT  = 4'd4;
  localparam logic [S_W-1:0] S_SRD      = 4'd5;
  localparam logic [S_W-1:0] S_SCMP     = 4'd6;
  localparam logic [S_W-1:0] S_LAST_RD  = 4'd7;
  localparam logic [S_W-1:0] S_LAST_WR  = 4'd8;
  localparam logic [S_W-1:0] S_SPLIT    = 4'd9;
  localparam logic [S_W-1:0] S_FRAC_OUT = 4'd10;
  localparam logic [S_W-1:0] S_SH_CHK   = 4'd11;
  localparam logic [S_W-1:0] S_SH_WR    = 4'd12;

  logic [S_W-1:0] state;
  logic [S_W-1:0] state_next;

  assign busy = (state != S_IDLE);

  // Next state and datapath command
  always_comb begin
    state_next  = state;
    ctl.op      = fia_pkg::OP_NONE;
    ctl.res_sel = fia_pkg::RES_NONE;
    ctl.status  = fia_pkg::ST_OK;
    ctl.last    = 1'b1;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          ctl.op     = fia_pkg::OP_LOAD;
          state_next = S_DECODE;
        end
      end
      S_DECODE: begin
        state_next = S_IDLE;
        if (stat.cmd == fia_pkg::CMD_INIT) begin
          state_next = S_FILL;
        end else if (stat.cmd == fia_pkg::CMD_ACQ) begin
          priority if (stat.q_zero) begin
            ctl.res_sel = fia_pkg::RES_ZERO;
            ctl.status  = fia_pkg::ST_BADQ;
          end else if (stat.q_whole && !stat.q_aligned) begin
            ctl.res_sel = fia_pkg::RES_ZERO;
            ctl.status  = fia_pkg::ST_BADQ;
          end else if (stat.q_whole && stat.k_over) begin
            ctl.res_sel = fia_pkg::RES_ZERO;
            ctl.status  = fia_pkg::ST_INSUFF;
          end else if (stat.q_whole) begin
            state_next = S_POP_RD;
          end else begin
            state_next = S_SRD;
          end
        end else if (stat.cmd == fia_pkg::CMD_REL) begin
          priority if (stat.q_zero || stat.q_over_one) begin
            ctl.res_sel = fia_pkg::RES_ZERO;
            ctl.status  = fia_pkg::ST_BADQ;
          end else if (stat.q_one && stat.ws_full) begin
            ctl.res_sel = fia_pkg::RES_ZERO;
            ctl.status  = fia_pkg::ST_FULL;
          end else if (stat.q_one) begin
            ctl.op      = fia_pkg::OP_PUSH;
            ctl.res_sel = fia_pkg::RES_ZERO;
          end else begin
            state_next = S_SRD;
          end
        end
      end
      // Init: write IDs 0..n-1 one per cycle
      S_FILL: begin
        if (stat.fill_done) begin
          ctl.op      = fia_pkg::OP_INIT_END;
          ctl.res_sel = fia_pkg::RES_ZERO;
          state_next  = S_IDLE;
        end else begin
          ctl.op = fia_pkg::OP_FILL;
        end
      end
      // Whole acquire: pop then emit, once per ID
      S_POP_RD: begin
        ctl.op     = fia_pkg::OP_POP;
        state_next = S_POP_OUT;
      end
      S_POP_OUT: begin
        ctl.res_sel = fia_pkg::RES_POP;
        ctl.last    = stat.pop_done;
        state_next  = stat.pop_done ? S_IDLE : S_POP_RD;
      end
      // Partial list scan, shared by fractional acquire and release
      S_SRD: begin
        if (stat.scan_end) begin
          state_next  = S_IDLE;
          ctl.res_sel = fia_pkg::RES_ZERO;
          if (stat.cmd == fia_pkg::CMD_ACQ) begin
            priority if (stat.ws_empty) begin
              ctl.status = fia_pkg::ST_INSUFF;
            end else if (stat.pl_full) begin
              ctl.status = fia_pkg::ST_FULL;
            end else begin
              ctl.op      = fia_pkg::OP_POP;
              ctl.res_sel = fia_pkg::RES_NONE;
              state_next  = S_SPLIT;
            end
          end else begin
            if (stat.pl_full) begin
              ctl.status = fia_pkg::ST_FULL;
            end else begin
              ctl.op = fia_pkg::OP_APPEND;
            end
          end
        end else begin
          ctl.op     = fia_pkg::OP_PRD;
          state_next = S_SCMP;
        end
      end
      S_SCMP: begin
        ctl.op     = fia_pkg::OP_NEXT;
        state_next = S_SRD;
        if (stat.cmd == fia_pkg::CMD_ACQ) begin
          if (stat.fit) begin
            ctl.op     = fia_pkg::OP_TAKE;
            state_next = stat.take_zero ? S_LAST_RD : S_FRAC_OUT;
          end
        end else if (stat.match) begin
          state_next  = S_IDLE;
          ctl.op      = fia_pkg::OP_NONE;
          ctl.res_sel = fia_pkg::RES_ZERO;
          priority if (stat.sum_over) begin
            ctl.status = fia_pkg::ST_OVER;
          end else if (stat.sum_one && stat.ws_full) begin
            ctl.status = fia_pkg::ST_FULL;
          end else if (stat.sum_one) begin
            ctl.op      = fia_pkg::OP_PUSH;
            ctl.res_sel = fia_pkg::RES_NONE;
            state_next  = S_SH_CHK;
          end else begin
            ctl.op = fia_pkg::OP_MERGE;
          end
        end
      end
      // Emptied entry: move the last entry into its slot
      S_LAST_RD: begin
        ctl.op     = fia_pkg::OP_PRD_LAST;
        state_next = S_LAST_WR;
      end
      S_LAST_WR: begin
        ctl.op     = fia_pkg::OP_MOVE_LAST;
        state_next = S_FRAC_OUT;
      end
      S_SPLIT: begin
        ctl.op     = fia_pkg::OP_SPLIT;
        state_next = S_FRAC_OUT;
      end
      S_FRAC_OUT: begin
        ctl.res_sel = fia_pkg::RES_FRAC;
        state_next  = S_IDLE;
      end
      // Promotion: close the gap, keeping order
      S_SH_CHK: begin
        if (stat.last_entry) begin
          ctl.op      = fia_pkg::OP_PC_DEC;
          ctl.res_sel = fia_pkg::RES_ZERO;
          state_next  = S_IDLE;
        end else begin
          ctl.op     = fia_pkg::OP_SHRD;
          state_next = S_SH_WR;
        end
      end
      S_SH_WR: begin
        ctl.op     = fia_pkg::OP_SHWR;
        state_next = S_SH_CHK;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule
